FILE: rtl/ctc_pkg.sv
// Package for the C token classifier: sizes, token kinds, result record,
// keyword and operator tables, character class functions.
// No dependencies.
package ctc_pkg;

  localparam int MaxWord  = 14;
  localparam int WordCntW = $clog2(MaxWord + 2);
  localparam int WordIdxW = $clog2(MaxWord);
  localparam int LenW     = 4;
  localparam int KwIdxW   = 4;
  localparam int SymW     = 16;
  localparam int NumKw    = 15;
  localparam int KwMaxLen = 8;
  localparam int KwCmpLen = (KwMaxLen < MaxWord) ? KwMaxLen : MaxWord;
  localparam int NumOp    = 17;
  localparam int MaxRes   = 3;
  localparam int ResIdxW  = $clog2(MaxRes);
  localparam int ResCntW  = $clog2(MaxRes + 1);
  localparam int CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CfgExtraA = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgExtraB = 1'b1;
  localparam logic [7:0] ExtraAReset = 8'd241;
  localparam logic [7:0] ExtraBReset = 8'd209;

  localparam logic [KwIdxW-1:0] NotKeyword  = 4'd15;
  localparam logic [LenW-1:0]   WordLenLong = 4'd15;

  typedef enum logic [2:0] {
    KindKeyword,
    KindHex,
    KindOctal,
    KindDecimal,
    KindBadWord,
    KindIdent,
    KindOper,
    KindPunct
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e         kind;
    logic [LenW-1:0]   word_len;
    logic [KwIdxW-1:0] kw_idx;
    logic [SymW-1:0]   sym;
  } tok_res_t;

  localparam int KwLen [NumKw] = '{3, 4, 4, 6, 2, 5, 3, 6, 5, 4, 2, 6, 4, 4, 8};

  localparam logic [8*KwMaxLen-1:0] KwText [NumKw] = '{
    "int", "char", "else", "return", "if", "while", "for", "struct",
    "break", "case", "do", "double", "long", "void", "unsigned"
  };

  localparam logic [SymW-1:0] OpText [NumOp] = '{
    {"=", 8'h00}, {"<", 8'h00}, {">", 8'h00}, "<=", ">=", "==", "!=",
    {"+", 8'h00}, {"-", 8'h00}, {"*", 8'h00}, {"/", 8'h00}, {"%", 8'h00},
    "&&", {"!", 8'h00}, "||", "++", "--"
  };

  // byte j of keyword i, counted from the first character
  function automatic logic [7:0] kw_byte(input int i, input int j);
    logic [8*KwMaxLen-1:0] t;
    t = KwText[i] << (8 * (KwMaxLen - KwLen[i]));
    return t[8*(KwMaxLen-1-j) +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_word_char(input logic [7:0] c, input logic [7:0] xa,
                                        input logic [7:0] xb);
    return is_digit(c) || ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) ||
           (c == "_") || (c == xa) || (c == xb);
  endfunction

  function automatic logic is_oper_char(input logic [7:0] c);
    return (c == "=") || (c == "<") || (c == ">") || (c == "!") || (c == "+") ||
           (c == "-") || (c == "&") || (c == "|") || (c == "*") || (c == "/") ||
           (c == "%");
  endfunction

endpackage

FILE: rtl/c_token_classifier.sv
// C token classifier top level: input register, word and operator buffers,
// per-byte classification and a result batch register.
// Depends on ctc_pkg.
//
// Usage:
//   in channel (in_valid_i/in_ready_o/character_i) takes one source byte per
//   transfer. out channel (out_valid_o/out_ready_i) delivers token records;
//   last_o marks the final record caused by a byte. cfg channel writes the
//   two extra word letters (index 0 and 1); cfg_ready_o is always high and
//   writes are expected only while the block is idle.
//   Each byte is held in the input register, then its records fill the batch.
//   Throughput: one byte per cycle while each byte makes at most one record
//   and the receiver is ready; a byte making k records holds the result batch
//   for k output transfers, since the result register has a single read port.
//   A byte that makes no record leaves the batch free for the next byte.
//   Reset clears the buffers' counts, the pending byte and the batch, and
//   loads the extra letters with 241 and 209.
//   When the receiver stalls the batch holds, the input register fills and
//   in_ready_o drops; nothing is dropped.
module c_token_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ctc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   character_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   token_kind_o,
  output logic [ctc_pkg::LenW-1:0]     word_length_o,
  output logic [ctc_pkg::KwIdxW-1:0]   keyword_index_o,
  output logic [ctc_pkg::SymW-1:0]     symbol_text_o,
  output logic                         last_o
);
  import ctc_pkg::*;

  logic [7:0]          extra_a_q, extra_b_q;
  logic                in_valid_q;
  logic [7:0]          char_q;
  logic [7:0]          word_q [MaxWord];
  logic [WordCntW-1:0] word_cnt_q;
  logic [7:0]          oper_q [2];
  logic [1:0]          oper_cnt_q;
  tok_res_t            res_q [MaxRes];
  tok_res_t            res_d [MaxRes];
  logic [ResCntW-1:0]  rem_q, res_cnt_d;
  logic [ResIdxW-1:0]  ptr_q;

  logic     batch_free, proc;
  logic     is_word, is_oper, word_done, oper_done, op_v, pu_v;
  logic     digits, bad, kw_hit;
  logic [KwIdxW-1:0] kw_idx;
  logic [SymW-1:0]   op_sym;
  tok_res_t wres, ores, pres, cur;

  assign cfg_ready_o = 1'b1;
  assign batch_free  = (rem_q == '0) || ((rem_q == ResCntW'(1)) && out_ready_i);
  assign proc        = in_valid_q && batch_free;
  assign in_ready_o  = !in_valid_q || proc;

  assign cur             = res_q[ptr_q];
  assign out_valid_o     = rem_q != '0;
  assign last_o          = rem_q == ResCntW'(1);
  assign token_kind_o    = cur.kind;
  assign word_length_o   = cur.word_len;
  assign keyword_index_o = cur.kw_idx;
  assign symbol_text_o   = cur.sym;

  always_comb begin
    is_word   = is_word_char(char_q, extra_a_q, extra_b_q);
    is_oper   = is_oper_char(char_q);
    word_done = !is_word && (word_cnt_q != '0);
    oper_done = !is_oper && (oper_cnt_q != 2'd0);
    pu_v      = char_q inside {"{", "}", ";", "(", ")", ",", "[", "]"};

    // keyword search, lowest index wins
    kw_idx = NotKeyword;
    for (int i = NumKw - 1; i >= 0; i--) begin
      kw_hit = (KwLen[i] <= MaxWord) && (word_cnt_q == WordCntW'(KwLen[i]));
      for (int j = 0; j < KwCmpLen; j++) begin
        if (j < KwLen[i]) begin
          kw_hit = kw_hit && (word_q[j] == kw_byte(i, j));
        end
      end
      if (kw_hit) begin
        kw_idx = KwIdxW'(i);
      end
    end

    digits = 1'b1;
    bad    = 1'b0;
    for (int j = 0; j < MaxWord; j++) begin
      if (j < word_cnt_q) begin
        if (!is_digit(word_q[j])) begin
          digits = 1'b0;
        end
        if ((word_q[j] == extra_a_q) || (word_q[j] == extra_b_q)) begin
          bad = 1'b1;
        end
      end
    end

    wres.word_len = LenW'(word_cnt_q);
    wres.kw_idx   = NotKeyword;
    wres.sym      = '0;
    if (word_cnt_q > WordCntW'(MaxWord)) begin
      wres.kind     = KindBadWord;
      wres.word_len = WordLenLong;
    end else if (kw_idx != NotKeyword) begin
      wres.kind   = KindKeyword;
      wres.kw_idx = kw_idx;
    end else if (word_q[0] == "0") begin
      if ((word_cnt_q >= WordCntW'(2)) && ((word_q[1] == "x") || (word_q[1] == "X"))) begin
        wres.kind = KindHex;
      end else begin
        wres.kind = KindOctal;
      end
    end else if (digits) begin
      wres.kind = KindDecimal;
    end else if (bad || is_digit(word_q[0])) begin
      wres.kind = KindBadWord;
    end else begin
      wres.kind = KindIdent;
    end

    op_sym = {oper_q[0], (oper_cnt_q == 2'd2) ? oper_q[1] : 8'h00};
    op_v   = 1'b0;
    for (int i = 0; i < NumOp; i++) begin
      if (op_sym == OpText[i]) begin
        op_v = 1'b1;
      end
    end
    op_v = op_v && oper_done && (oper_cnt_q != 2'd3);

    ores = '{kind: KindOper, word_len: '0, kw_idx: NotKeyword, sym: op_sym};
    pres = '{kind: KindPunct, word_len: '0, kw_idx: NotKeyword, sym: {char_q, 8'h00}};

    for (int k = 0; k < MaxRes; k++) begin
      res_d[k] = pres;
    end
    res_cnt_d = '0;
    if (word_done) begin
      res_d[res_cnt_d[ResIdxW-1:0]] = wres;
      res_cnt_d = res_cnt_d + 1'b1;
    end
    if (op_v) begin
      res_d[res_cnt_d[ResIdxW-1:0]] = ores;
      res_cnt_d = res_cnt_d + 1'b1;
    end
    if (pu_v) begin
      res_d[res_cnt_d[ResIdxW-1:0]] = pres;
      res_cnt_d = res_cnt_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extra_a_q  <= ExtraAReset;
      extra_b_q  <= ExtraBReset;
      in_valid_q <= 1'b0;
      word_cnt_q <= '0;
      oper_cnt_q <= 2'd0;
      rem_q      <= '0;
      ptr_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgExtraA) begin
          extra_a_q <= cfg_data_i;
        end else if (cfg_index_i == CfgExtraB) begin
          extra_b_q <= cfg_data_i;
        end
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc) begin
        if (is_word) begin
          if (word_cnt_q <= WordCntW'(MaxWord)) begin
            word_cnt_q <= word_cnt_q + 1'b1;
          end
        end else begin
          word_cnt_q <= '0;
        end
        if (is_oper) begin
          if (oper_cnt_q != 2'd3) begin
            oper_cnt_q <= oper_cnt_q + 1'b1;
          end
        end else begin
          oper_cnt_q <= 2'd0;
        end
        rem_q <= res_cnt_d;
        ptr_q <= '0;
      end else if (out_valid_o && out_ready_i) begin
        rem_q <= rem_q - 1'b1;
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= character_i;
    end
    if (proc) begin
      if (is_word && (word_cnt_q < WordCntW'(MaxWord))) begin
        word_q[word_cnt_q[WordIdxW-1:0]] <= char_q;
      end
      if (is_oper && (oper_cnt_q < 2'd2)) begin
        oper_q[oper_cnt_q[0]] <= char_q;
      end
      for (int k = 0; k < MaxRes; k++) begin
        res_q[k] <= res_d[k];
      end
    end
  end

  a_batch_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("result batch ended before its last record");

  a_word_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_cnt_q <= WordCntW'(MaxWord + 1))
    else $error("word count past saturation");

  a_batch_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ResCntW + 1)'(rem_q) + (ResCntW + 1)'(ptr_q) <= (ResCntW + 1)'(MaxRes))
    else $error("batch pointer out of range");

  a_symbol_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == KindOper) || (token_kind_o == KindPunct))
    |-> (word_length_o == '0) && (keyword_index_o == NotKeyword) &&
        (symbol_text_o[15:8] != 8'h00))
    else $error("symbol record with word fields set");

endmodule

FILE: sim/c_token_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench for c_token_classifier: directed byte table, then random C-like text
// under several extra-letter settings, checked against a local token predictor.
// Depends on ctc_pkg and the c_token_classifier RTL.
module c_token_classifier_tb;
  import ctc_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 8;
  localparam int LongHold    = 120;
  localparam int NumPhases   = 7;
  localparam int PhaseItems  = 27;
  localparam int NumRows     = 25;

  typedef struct packed {
    tok_kind_e         kind;
    logic [LenW-1:0]   len;
    logic [KwIdxW-1:0] kw;
    logic [SymW-1:0]   sym;
    logic              last;
  } tok_rec_t;

  typedef struct packed {
    logic [7:0] ch;
    bit         typed;
    tok_rec_t   res;
  } stim_row_t;

  localparam tok_rec_t NoRec = '{KindKeyword, 4'd0, 4'd0, 16'h0000, 1'b0};

  // typed rows hold the single token that byte must produce
  localparam stim_row_t DirRows [NumRows] = '{
    '{"d", 1'b0, NoRec}, '{"o", 1'b0, NoRec},
    '{" ", 1'b1, '{KindKeyword, 4'd2, 4'd10, 16'h0000, 1'b1}},
    '{"0", 1'b0, NoRec}, '{"x", 1'b0, NoRec}, '{"(", 1'b0, NoRec},
    '{"0", 1'b0, NoRec},
    '{8'h00, 1'b1, '{KindOctal, 4'd1, NotKeyword, 16'h0000, 1'b1}},
    '{"9", 1'b0, NoRec},
    '{8'hFF, 1'b1, '{KindDecimal, 4'd1, NotKeyword, 16'h0000, 1'b1}},
    '{"7", 1'b0, NoRec}, '{"a", 1'b0, NoRec}, '{ExtraAReset, 1'b0, NoRec},
    '{"}", 1'b0, NoRec},
    '{"_", 1'b0, NoRec}, '{"Z", 1'b0, NoRec},
    '{"+", 1'b1, '{KindIdent, 4'd2, NotKeyword, 16'h0000, 1'b1}},
    '{"+", 1'b0, NoRec}, '{";", 1'b0, NoRec},
    '{"<", 1'b0, NoRec}, '{"<", 1'b0, NoRec}, '{"=", 1'b0, NoRec},
    '{",", 1'b1, '{KindPunct, 4'd0, NotKeyword, {",", 8'h00}, 1'b1}},
    '{"&", 1'b0, NoRec}, '{"]", 1'b0, NoRec}
  };

  string kw_names [NumKw] = '{"int", "char", "else", "return", "if", "while", "for",
                              "struct", "break", "case", "do", "double", "long", "void",
                              "unsigned"};
  string op_names [NumOp] = '{"=", "<", ">", "<=", ">=", "==", "!=", "+", "-", "*", "/",
                              "%", "&&", "!", "||", "++", "--"};
  string punct_set = "{};(),[]";
  string oper_set  = "=<>!+-&|*/%";
  string digit_set = "0123456789";
  string hex_set   = "0123456789abcdefABCDEF";
  string id_head   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string id_body   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgExtraA;
  logic [7:0]          cfg_data_i  = 8'h00;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [7:0]          character_i = 8'h00;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [2:0]          token_kind_o;
  logic [LenW-1:0]     word_length_o;
  logic [KwIdxW-1:0]   keyword_index_o;
  logic [SymW-1:0]     symbol_text_o;
  logic                last_o;

  // predictor state
  logic [7:0] letter_a, letter_b;
  logic [7:0] word_text [MaxWord];
  int         word_len;
  logic [7:0] op_text [2];
  int         op_len;

  tok_rec_t   step_recs[$];
  tok_rec_t   token_q[$];
  logic [7:0] src_text[$];
  int         err_cnt = 0;
  int         cyc_cnt = 0;
  bit         tx_steady = 1'b0;
  bit         rx_steady = 1'b0;
  bit         hold_req = 1'b0;

  c_token_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .word_length_o  (word_length_o),
    .keyword_index_o(keyword_index_o),
    .symbol_text_o  (symbol_text_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CycleLimit) begin
      $display("%0t: timeout, %0d tokens pending", $time, token_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic bit word_letter(input logic [7:0] c);
    return (c inside {["0":"9"], ["A":"Z"], ["a":"z"], "_"}) || c == letter_a ||
           c == letter_b;
  endfunction

  function automatic bit oper_letter(input logic [7:0] c);
    return c inside {"=", "<", ">", "!", "+", "-", "&", "|", "*", "/", "%"};
  endfunction

  function automatic tok_rec_t finish_word();
    tok_rec_t r;
    int       kw;
    bit       all_digits, tainted, same;
    r = '{KindBadWord, WordLenLong, NotKeyword, 16'h0000, 1'b0};
    if (word_len > MaxWord) return r;
    r.len = 4'(word_len);
    kw = -1;
    for (int i = NumKw - 1; i >= 0; i--) begin
      same = (kw_names[i].len() == word_len);
      for (int j = 0; j < word_len && same; j++) same = (kw_names[i][j] == word_text[j]);
      if (same) kw = i;
    end
    if (kw >= 0) begin
      r.kind = KindKeyword;
      r.kw = 4'(kw);
      return r;
    end
    if (word_text[0] == "0") begin
      if (word_len >= 2 && word_text[1] inside {"x", "X"}) r.kind = KindHex;
      else r.kind = KindOctal;
      return r;
    end
    all_digits = 1'b1;
    tainted = 1'b0;
    for (int i = 0; i < word_len; i++) begin
      if (!(word_text[i] inside {["0":"9"]})) all_digits = 1'b0;
      if (word_text[i] == letter_a || word_text[i] == letter_b) tainted = 1'b1;
    end
    if (all_digits) r.kind = KindDecimal;
    else if (tainted || word_text[0] inside {["0":"9"]}) r.kind = KindBadWord;
    else r.kind = KindIdent;
    return r;
  endfunction

  // tokens caused by one byte, in output order, left in step_recs
  function automatic void predict_tokens(input logic [7:0] c);
    logic [7:0] second, op1;
    bit         hit;
    step_recs.delete();
    if (word_letter(c)) begin
      if (word_len < MaxWord) word_text[word_len] = c;
      if (word_len <= MaxWord) word_len++;
    end else if (word_len != 0) begin
      step_recs.push_back(finish_word());
      word_len = 0;
    end
    if (oper_letter(c)) begin
      if (op_len < 2) op_text[op_len] = c;
      if (op_len < 3) op_len++;
    end else if (op_len != 0) begin
      if (op_len <= 2) begin
        second = (op_len == 2) ? op_text[1] : 8'h00;
        hit = 1'b0;
        for (int i = 0; i < NumOp; i++) begin
          op1 = (op_names[i].len() == 2) ? op_names[i][1] : 8'h00;
          if (op_names[i][0] == op_text[0] && op1 == second) hit = 1'b1;
        end
        if (hit)
          step_recs.push_back('{KindOper, 4'd0, NotKeyword, {op_text[0], second}, 1'b0});
      end
      op_len = 0;
    end
    for (int i = 0; i < punct_set.len(); i++) begin
      if (c == punct_set[i]) begin
        step_recs.push_back('{KindPunct, 4'd0, NotKeyword, {c, 8'h00}, 1'b0});
        break;
      end
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    tok_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (token_q.size() == 0) begin
        $display("%0t: unexpected token: kind %0d len %0d kw %0d sym %h", $time,
                 token_kind_o, word_length_o, keyword_index_o, symbol_text_o);
        err_cnt++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 16'(want.kind), 16'(token_kind_o));
        check_field("word_length", 16'(want.len), 16'(word_length_o));
        check_field("keyword_index", 16'(want.kw), 16'(keyword_index_o));
        check_field("symbol_text", want.sym, symbol_text_o);
        check_field("last", 16'(want.last), 16'(last_o));
      end
    end
  end

  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        hold_req = 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (!rx_steady && $urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
        repeat (n) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_chars(input string set, input int n);
    for (int i = 0; i < n; i++) src_text.push_back(set[$urandom_range(0, set.len() - 1)]);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endfunction

  // one random C-like token, sometimes followed by a separator
  function automatic void make_tokens();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      add_text(kw_names[$urandom_range(0, NumKw - 1)]);
    end else if (r < 20) begin
      add_text("0");
      add_chars("xX", 1);
      add_chars(hex_set, $urandom_range(0, 4));
    end else if (r < 26) begin
      add_text("0");
      add_chars("01234567", $urandom_range(0, 3));
    end else if (r < 33) begin
      add_chars("123456789", 1);
      add_chars(digit_set, $urandom_range(0, 4));
    end else if (r < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 5);
      add_chars(id_head, 1);
      add_chars(id_body, n);
    end else if (r < 51) begin
      if ($urandom_range(0, 1)) add_chars(digit_set, 1);
      else add_chars(id_head, 1);
      add_chars(id_body, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) src_text.push_back($urandom_range(0, 1) ? letter_a : letter_b);
    end else if (r < 69) begin
      if ($urandom_range(0, 2) != 0) add_text(op_names[$urandom_range(0, NumOp - 1)]);
      else add_chars(oper_set, $urandom_range(1, 3));
    end else if (r < 81) begin
      add_chars(punct_set, 1);
    end else if (r < 91) begin
      add_chars(" \t\n", 1);
    end else begin
      src_text.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) add_chars(" ;,)", 1);
  endfunction

  task automatic send_char(input logic [7:0] c, input bit typed, input tok_rec_t fixed_rec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    predict_tokens(c);
    if (typed) token_q.push_back(fixed_rec);
    else foreach (step_recs[i]) token_q.push_back(step_recs[i]);
  endtask

  // wait for all tokens, then idle with the input channel quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (token_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic load_letters(input logic [7:0] a, input logic [7:0] b);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgExtraA;
    cfg_data_i  <= a;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    letter_a = a;
    cfg_index_i <= CfgExtraB;
    cfg_data_i  <= b;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    letter_b = b;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] phase_a [NumPhases];
    logic [7:0] phase_b [NumPhases];
    int         sent;
    phase_a = '{ExtraAReset, "(", 8'h00, "[", 8'hFF, 8'h00, 8'h00};
    phase_b = '{ExtraBReset, "+", 8'hFF, "$", 8'h00, 8'h00, 8'h00};
    letter_a = ExtraAReset;
    letter_b = ExtraBReset;
    word_len = 0;
    op_len = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) send_char(DirRows[i].ch, DirRows[i].typed, DirRows[i].res);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      if (p >= 5) begin
        phase_a[p] = 8'($urandom_range(0, 255));
        phase_b[p] = 8'($urandom_range(0, 255));
      end
      load_letters(phase_a[p], phase_b[p]);
      tx_steady = (p == 2) || (p == 4);
      rx_steady = (p == 4);
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < PhaseItems) begin
        make_tokens();
        while (src_text.size() > 0) begin
          send_char(src_text.pop_front(), 1'b0, NoRec);
          sent++;
        end
      end
    end

    settle();
    if (err_cnt == 0 && token_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ctc_pkg.sv
rtl/c_token_classifier.sv
sim/c_token_classifier_tb.sv
